// ===== hdl/rwr_pkg.sv =====
// ----------------------------------------------------------------------------
// rwr_pkg
// shared types and constants of the receive window reorder engine
// ----------------------------------------------------------------------------
package rwr_pkg;

  localparam int SEQ_W = 32;
  localparam int LEN_W = 10;
  localparam int TAG_W = 8;
  localparam int SEGS_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SEGMENTS = 2'd1;

  localparam logic [SEQ_W-1:0] INITIAL_SEQ_RST = 32'd0;
  localparam logic [SEGS_W-1:0] WINDOW_SEGMENTS_RST = 16'd16;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_num;
    logic [LEN_W-1:0] payload_len;
    logic             push_req;
    logic [TAG_W-1:0] buffer_tag;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] out_seq;
    logic [LEN_W-1:0] out_len;
    logic             out_push;
    logic [TAG_W-1:0] out_tag;
    logic             last_release;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             push;
    logic [TAG_W-1:0] tag;
  } pend_data_t;

endpackage

// ===== hdl/rwr_queue.sv =====
// ----------------------------------------------------------------------------
// rwr_queue
// two-entry intake queue between the input channel and the reorder engine
// ----------------------------------------------------------------------------
module rwr_queue import rwr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_pop,
  output in_item_t q_item
);

  localparam logic [1:0] FULL_COUNT = 2'd2;

  in_item_t   slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign in_stall = (count_r == FULL_COUNT);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hdl/rwr_engine.sv =====
// ----------------------------------------------------------------------------
// rwr_engine
// window check, pending table and in-order release chain
// ----------------------------------------------------------------------------
module rwr_engine import rwr_pkg::*; #(
  parameter int PENDING_DEPTH   = 16,
  parameter int SEGMENT_PAYLOAD = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  in_item_t              q_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  localparam int IDX_W  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int SP_W   = $clog2(SEGMENT_PAYLOAD + 1);
  localparam int PROD_W = SEGS_W + SP_W;
  localparam logic [SP_W-1:0] SP_C = SP_W'(SEGMENT_PAYLOAD);
  localparam logic [SEQ_W-1:0] SPAN_RST =
    SEQ_W'(SEGMENT_PAYLOAD * WINDOW_SEGMENTS_RST);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_t;

  state_t             state_r;
  logic [SEQ_W-1:0]   init_seq_r;
  logic [SEQ_W-1:0]   span_r;
  logic               restart_r;
  logic [SEQ_W-1:0]   base_r;
  logic [SEQ_W-1:0]   end_r;
  logic [PENDING_DEPTH-1:0] pend_valid_r;
  logic [SEQ_W-1:0]   pend_seq_r [PENDING_DEPTH];
  pend_data_t         pend_mem [PENDING_DEPTH];
  pend_data_t         rd_data_r;
  in_item_t           hold_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [PROD_W-1:0]  span_prod;
  logic               in_win;
  logic               at_base;
  logic               store_en;
  logic [PENDING_DEPTH-1:0] match_vec;
  logic               match_any;
  logic [IDX_W-1:0]   match_idx;
  logic               free_any;
  logic [IDX_W-1:0]   free_idx;
  logic               out_free;
  logic               rd_en;

  assign span_prod = {{SP_W{1'b0}}, cfg_wdata[SEGS_W-1:0]} * {{SEGS_W{1'b0}}, SP_C};

  assign in_win   = !((q_item.seq_num < base_r) || (q_item.seq_num > end_r));
  assign at_base  = (q_item.seq_num == base_r);
  assign q_pop    = (state_r == ST_IDLE) && !restart_r && q_valid;
  assign store_en = q_pop && in_win && !at_base && free_any;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_en    = (state_r == ST_SCAN) && out_free && match_any;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // match against base and free slot search, lowest slot wins
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
      match_vec[i] = pend_valid_r[i] && (pend_seq_r[i] == base_r);
      if (match_vec[i]) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!pend_valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      pend_mem[free_idx] <= '{len: q_item.payload_len, push: q_item.push_req,
                              tag: q_item.buffer_tag};
    end
    if (rd_en) begin
      rd_data_r <= pend_mem[match_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      init_seq_r   <= INITIAL_SEQ_RST;
      span_r       <= SPAN_RST;
      restart_r    <= 1'b1;
      pend_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // window restart after reset or a register write
      if (restart_r) begin
        base_r       <= init_seq_r;
        end_r        <= init_seq_r + span_r;
        pend_valid_r <= '0;
        restart_r    <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_INITIAL_SEQ: begin
            init_seq_r <= cfg_wdata;
            restart_r  <= 1'b1;
          end
          CFG_WINDOW_SEGMENTS: begin
            span_r     <= SEQ_W'(span_prod);
            restart_r  <= 1'b1;
          end
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (q_pop && in_win) begin
            if (at_base) begin
              hold_r  <= q_item;
              base_r  <= base_r + SEQ_W'(q_item.payload_len);
              end_r   <= end_r + SEQ_W'(q_item.payload_len);
              state_r <= ST_SCAN;
            end else if (free_any) begin
              pend_valid_r[free_idx] <= 1'b1;
              pend_seq_r[free_idx]   <= q_item.seq_num;
            end
          end
        end
        ST_SCAN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_item_r  <= '{out_seq: hold_r.seq_num, out_len: hold_r.payload_len,
                             out_push: hold_r.push_req, out_tag: hold_r.buffer_tag,
                             last_release: !match_any};
            if (match_any) begin
              pend_valid_r[match_idx] <= 1'b0;
              hold_r.seq_num          <= pend_seq_r[match_idx];
              state_r                 <= ST_READ;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_READ: begin
          hold_r.payload_len <= rd_data_r.len;
          hold_r.push_req    <= rd_data_r.push;
          hold_r.buffer_tag  <= rd_data_r.tag;
          base_r             <= base_r + SEQ_W'(rd_data_r.len);
          end_r              <= end_r + SEQ_W'(rd_data_r.len);
          state_r            <= ST_SCAN;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/receive_window_reorder.sv =====
// ----------------------------------------------------------------------------
// receive_window_reorder
// receive-side segment reorder engine for a reliable datagram link
// ----------------------------------------------------------------------------
// segment descriptors enter on in_valid/in_stall/in_item into a two-entry
// queue; released descriptors leave on out_valid/out_stall/out_item, one
// transaction per release, last_release set on the final one of a chain
// registers are written on cfg_valid/cfg_ready/cfg_index/cfg_wdata; the user must
// write them only while idle, which the block does not enforce; cfg_ready is always high
// a segment at the window base is released through the intake queue slot, the
// hold register and the output register on an unstalled output; each chained release
// from the pending table goes through the match state (ST_SCAN) and a table read (ST_READ)
// a dropped or stored segment leaves the engine in its idle state
// reset and every register write restart the window and clear the pending
// table; while the restart is pending, queued segments wait
// a stall on the output holds the engine in its match cycle; the intake
// queue keeps taking segments until both entries are full
// ----------------------------------------------------------------------------
module receive_window_reorder import rwr_pkg::*; #(
  parameter int PENDING_DEPTH   = 16,
  parameter int SEGMENT_PAYLOAD = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic     q_valid;
  logic     q_pop;
  in_item_t q_item;

  assign cfg_ready = 1'b1;

  rwr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  rwr_engine #(
    .PENDING_DEPTH   (PENDING_DEPTH),
    .SEGMENT_PAYLOAD (SEGMENT_PAYLOAD)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
